// ===== rtl/b64d_pkg.sv =====
// Package for the Base64 stream decoder.
// Holds the token type passed from the front end to the back end, and shared constants.
// No dependencies.
package b64d_pkg;

    // Kinds of classified character.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_SKIP = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Sextet values of the two alphabet-dependent symbols.
    localparam logic [5:0] CODE_62 = 6'h3E;
    localparam logic [5:0] CODE_63 = 6'h3F;

    // Default number of entries in the token queue (power of two, at least two).
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] value;
        logic       last;
    } t_token;

endpackage

// ===== rtl/b64d_front.sv =====
// Front end of the Base64 stream decoder: accepts characters and classifies them.
// Each accepted character becomes one token that is pushed into the token queue.
// Depends on b64d_pkg.
module b64d_front (
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char_in,
    input  logic            i_last_char,
    input  logic            i_queue_full,
    output logic            o_push,
    output b64d_pkg::t_token o_token
);
    import b64d_pkg::*;

    logic [1:0] kind;
    logic [5:0] value;

    always_comb begin
        kind  = KIND_DATA;
        value = 6'd0;
        if (i_char_in >= 8'h41 && i_char_in <= 8'h5A) begin
            value = 6'(i_char_in - 8'h41);
        end else if (i_char_in >= 8'h61 && i_char_in <= 8'h7A) begin
            value = 6'(i_char_in - 8'h61 + 8'd26);
        end else if (i_char_in >= 8'h30 && i_char_in <= 8'h39) begin
            value = 6'(i_char_in - 8'h30 + 8'd52);
        end else if (i_char_in == 8'h2B || i_char_in == 8'h2D) begin
            value = CODE_62;
        end else if (i_char_in == 8'h2F || i_char_in == 8'h5F) begin
            value = CODE_63;
        end else if (i_char_in == 8'h0A || i_char_in == 8'h0D || i_char_in == 8'h3D) begin
            kind = KIND_SKIP;
        end else begin
            kind = KIND_BAD;
        end
    end

    assign o_ready       = !i_queue_full;
    assign o_push        = i_valid && !i_queue_full;
    assign o_token.kind  = kind;
    assign o_token.value = value;
    assign o_token.last  = i_last_char;

endmodule

// ===== rtl/b64d_queue.sv =====
// Short token queue between the front and back ends of the Base64 decoder.
// A register FIFO whose depth is a power of two; depends on b64d_pkg.
module b64d_queue #(
    parameter int QUEUE_DEPTH = b64d_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64d_pkg::t_token i_token,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output b64d_pkg::t_token o_token
);
    import b64d_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

// ===== rtl/b64d_back.sv =====
// Back end of the Base64 decoder: packs sextets into bytes and holds the result register.
// Keeps the pending bits, their count and the sticky error flag; depends on b64d_pkg.
module b64d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_token_valid,
    input  b64d_pkg::t_token i_token,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_byte_valid,
    output logic             o_message_end,
    output logic             o_status
);
    import b64d_pkg::*;

    logic [5:0]  r_pending_bits;
    logic [2:0]  r_pending_count;
    logic        r_error_seen;
    logic [5:0]  n_pending_bits;
    logic [2:0]  n_pending_count;
    logic        n_error_seen;

    logic        r_out_valid;
    logic [7:0]  r_data_byte;
    logic        r_byte_valid;
    logic        r_message_end;
    logic        r_status;

    logic [11:0] acc;
    logic [2:0]  rem;
    logic        have_byte;
    logic [7:0]  byte_val;
    logic        pop;
    logic        emit;

    // A token is taken whenever the result register is free or being emptied.
    assign pop   = i_token_valid && (!r_out_valid || i_ready);
    assign o_pop = pop;

    assign acc = {r_pending_bits, i_token.value};
    assign rem = r_pending_count - 3'd2;

    always_comb begin
        n_pending_bits  = r_pending_bits;
        n_pending_count = r_pending_count;
        n_error_seen    = r_error_seen;
        have_byte       = 1'b0;
        byte_val        = 8'd0;
        case (i_token.kind)
            KIND_BAD: begin
                n_error_seen = 1'b1;
            end
            KIND_DATA: begin
                if (!r_error_seen) begin
                    if (r_pending_count >= 3'd2) begin
                        have_byte       = 1'b1;
                        byte_val        = 8'(acc >> rem);
                        n_pending_bits  = 6'(acc & ((12'd1 << rem) - 12'd1));
                        n_pending_count = rem;
                    end else begin
                        n_pending_bits  = i_token.value;
                        n_pending_count = 3'd6;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign emit = have_byte || i_token.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_bits  <= '0;
            r_pending_count <= '0;
            r_error_seen    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= emit;
                if (i_token.last) begin
                    r_pending_bits  <= '0;
                    r_pending_count <= '0;
                    r_error_seen    <= 1'b0;
                end else begin
                    r_pending_bits  <= n_pending_bits;
                    r_pending_count <= n_pending_count;
                    r_error_seen    <= n_error_seen;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_data_byte   <= byte_val;
            r_byte_valid  <= have_byte;
            r_message_end <= i_token.last;
            r_status      <= n_error_seen;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_data_byte   = r_data_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_message_end = r_message_end;
    assign o_status      = r_status;

endmodule

// ===== rtl/base64_stream_decoder_core.sv =====
// Top level of the Base64 stream decoder: front end, token queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// The decoder takes one text character per transfer and sustains one character per
// clock cycle while the token queue is not full. Letters, digits, '+'/'-' and '/'/'_'
// each add six bits, CR, LF and '=' are skipped, and anything else sets a sticky error
// that suppresses all further bytes of the message. A result is produced for every
// completed byte and for the character marked last, which carries the message status
// and clears all state. A character is classified in the cycle it is accepted and
// written to a short token queue; the packing stage takes one token per cycle into its
// result register whenever that register is free or being emptied. The packing
// register, which carries the pending bits from one character to the next, sets the
// rate. The queue lets input transfers continue while a result waits to be taken.
module base64_stream_decoder_core #(
    parameter int QUEUE_DEPTH = b64d_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_message_end,
    output logic       o_status
);
    import b64d_pkg::*;

    t_token in_token;
    t_token out_token;
    logic   push;
    logic   full;
    logic   token_valid;
    logic   pop;

    b64d_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_in    (i_char_in),
        .i_last_char  (i_last_char),
        .i_queue_full (full),
        .o_push       (push),
        .o_token      (in_token)
    );

    b64d_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (in_token),
        .o_full  (full),
        .o_valid (token_valid),
        .i_pop   (pop),
        .o_token (out_token)
    );

    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_token_valid (token_valid),
        .i_token       (out_token),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_byte   (o_data_byte),
        .o_byte_valid  (o_byte_valid),
        .o_message_end (o_message_end),
        .o_status      (o_status)
    );

endmodule
